// ===== hdl/ckx_pkg.sv =====
// ----------------------------------------------------------------------------
// ckx_pkg
// Shared types, constants and helpers for the canonical k-mer extractor.
// ----------------------------------------------------------------------------
package ckx_pkg;

  // Longest read handled; characters beyond it are dropped.
  localparam int unsigned MaxReadLen = 4096;
  // Position counter holds 0..MaxReadLen.
  localparam int unsigned PosW       = $clog2(MaxReadLen + 1);
  // Last N position holds -1..MaxReadLen-1, signed.
  localparam int unsigned LupW       = PosW + 1;
  // Headroom for the window compares.
  localparam int unsigned CmpW       = PosW + 2;

  localparam int unsigned KmerW      = 64;
  localparam int unsigned KLenW      = 6;
  localparam int unsigned StartPosW  = 12;
  localparam int unsigned ReadIdxW   = 24;
  localparam int unsigned CharW      = 8;
  localparam int unsigned CfgDataW   = KLenW;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [KLenW-1:0] KMin     = KLenW'(1);
  localparam logic [KLenW-1:0] KMax     = KLenW'(32);
  localparam logic [KLenW-1:0] KReset   = KLenW'(21);
  localparam logic             ExclNRst = 1'b1;

  localparam logic [CharW-1:0] ChAUp = 8'h41;
  localparam logic [CharW-1:0] ChALo = 8'h61;
  localparam logic [CharW-1:0] ChCUp = 8'h43;
  localparam logic [CharW-1:0] ChCLo = 8'h63;
  localparam logic [CharW-1:0] ChGUp = 8'h47;
  localparam logic [CharW-1:0] ChGLo = 8'h67;
  localparam logic [CharW-1:0] ChTUp = 8'h54;
  localparam logic [CharW-1:0] ChTLo = 8'h74;
  localparam logic [CharW-1:0] ChNUp = 8'h4E;
  localparam logic [CharW-1:0] ChNLo = 8'h6E;

  localparam logic [1:0] CodeA = 2'd0;
  localparam logic [1:0] CodeC = 2'd1;
  localparam logic [1:0] CodeG = 2'd2;
  localparam logic [1:0] CodeT = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKmerLength = 1'b0,
    CfgExcludeN   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CharW-1:0]    base_char;
    logic [ReadIdxW-1:0] read_index;
    logic                last_in_read;
  } base_req_t;

  typedef struct packed {
    logic [KmerW-1:0]     kmer_code;
    logic                 is_reverse;
    logic [StartPosW-1:0] start_position;
    logic [ReadIdxW-1:0]  kmer_read_index;
  } kmer_req_t;

  typedef struct packed {
    logic [KLenW-1:0] kmer_length;
    logic             exclude_n;
  } cfg_t;

  // Input stage towards the core
  typedef struct packed {
    logic      valid;
    base_req_t req;
  } base_step_t;

  // Core towards the output stage
  typedef struct packed {
    logic      valid;
    kmer_req_t req;
  } kmer_res_t;

  typedef struct packed {
    logic       known;
    logic [1:0] code;
  } base_code_t;

  function automatic base_code_t base_code(input logic [CharW-1:0] ch);
    base_code_t r;
    r.known = 1'b1;
    r.code  = CodeA;
    if (ch == ChAUp || ch == ChALo) begin
      r.code = CodeA;
    end else if (ch == ChCUp || ch == ChCLo) begin
      r.code = CodeC;
    end else if (ch == ChGUp || ch == ChGLo) begin
      r.code = CodeG;
    end else if (ch == ChTUp || ch == ChTLo) begin
      r.code = CodeT;
    end else begin
      r.known = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/ckx_in_stage.sv =====
// ----------------------------------------------------------------------------
// ckx_in_stage
// Input register: holds one request until the core consumes it.
// ----------------------------------------------------------------------------
module ckx_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  ckx_pkg::base_req_t in_req_i,
  output logic               in_stall_o,
  input  logic               advance_i,
  output ckx_pkg::base_step_t step_o
);

  logic               valid_q, valid_d;
  ckx_pkg::base_req_t req_q;
  logic               take;

  // Free when empty or draining this cycle
  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= in_req_i;
    end
  end

  assign step_o.valid = valid_q;
  assign step_o.req   = req_q;

endmodule

// ===== hdl/ckx_kmer_core.sv =====
// ----------------------------------------------------------------------------
// ckx_kmer_core
// Rolling forward / reverse-complement words, N tracking and canonical pick.
// ----------------------------------------------------------------------------
module ckx_kmer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ckx_pkg::cfg_t       cfg_i,
  input  ckx_pkg::base_step_t step_i,
  input  logic                advance_i,
  output ckx_pkg::kmer_res_t  res_o
);

  localparam int unsigned KmerShW = $clog2(ckx_pkg::KmerW) + 1;

  logic [ckx_pkg::KmerW-1:0]       fwd_q, fwd_d, rev_q, rev_d;
  logic [ckx_pkg::PosW-1:0]        cnt_q, cnt_d;
  logic signed [ckx_pkg::LupW-1:0] lup_q, lup_d;

  logic [ckx_pkg::KLenW-1:0]       k_eff;
  logic [ckx_pkg::KLenW-2:0]       half;
  logic                            active;
  logic                            is_n;
  logic                            rec_n;
  ckx_pkg::base_code_t             bc;
  logic [ckx_pkg::KmerW-1:0]       mask;
  logic [ckx_pkg::KmerW-1:0]       fwd_n, rev_n, ins;
  logic [KmerShW-1:0]              mask_sh;
  logic [KmerShW-2:0]              ins_sh;
  logic signed [ckx_pkg::CmpW-1:0] y_s, k_s, lup_s, thr_s, lup_new_s, win_s, start_s;
  logic                            emit;

  always_comb begin
    if (cfg_i.kmer_length == '0) begin
      k_eff = ckx_pkg::KMin;
    end else if (cfg_i.kmer_length > ckx_pkg::KMax) begin
      k_eff = ckx_pkg::KMax;
    end else begin
      k_eff = cfg_i.kmer_length;
    end
  end

  assign half   = (ckx_pkg::KLenW - 1)'((k_eff - ckx_pkg::KMin) >> 1);
  assign active = (cnt_q < ckx_pkg::PosW'(ckx_pkg::MaxReadLen));
  assign bc     = ckx_pkg::base_code(step_i.req.base_char);
  assign is_n   = (step_i.req.base_char == ckx_pkg::ChNUp) ||
                  (step_i.req.base_char == ckx_pkg::ChNLo);

  // N record position, with the offset exception
  assign y_s    = ckx_pkg::CmpW'(cnt_q);
  assign k_s    = ckx_pkg::CmpW'(k_eff);
  assign lup_s  = ckx_pkg::CmpW'(lup_q);
  assign thr_s  = lup_s + ckx_pkg::CmpW'(half) - ckx_pkg::CmpW'(1);
  assign rec_n  = cfg_i.exclude_n && is_n && (y_s != thr_s);
  assign lup_new_s = rec_n ? y_s : lup_s;

  // Shift words; 2k = 64 gives an all-ones mask
  assign mask_sh = KmerShW'({k_eff, 1'b0});
  assign mask    = ~({ckx_pkg::KmerW{1'b1}} << mask_sh);
  assign ins_sh  = (KmerShW - 1)'({k_eff - ckx_pkg::KMin, 1'b0});
  assign ins     = ckx_pkg::KmerW'(2'd3 - bc.code) << ins_sh;
  assign fwd_n   = ((fwd_q << 2) | (bc.known ? ckx_pkg::KmerW'(bc.code) : '0)) & mask;
  assign rev_n   = ((rev_q >> 2) | (bc.known ? ins : '0)) & mask;

  assign win_s   = y_s - k_s;
  assign start_s = win_s + ckx_pkg::CmpW'(1);
  assign emit    = active && (lup_new_s <= win_s) && (fwd_n != rev_n);

  assign res_o.valid                   = step_i.valid && emit;
  assign res_o.req.is_reverse          = rev_n < fwd_n;
  assign res_o.req.kmer_code           = (rev_n < fwd_n) ? rev_n : fwd_n;
  assign res_o.req.start_position      = start_s[ckx_pkg::StartPosW-1:0];
  assign res_o.req.kmer_read_index     = step_i.req.read_index;

  always_comb begin
    fwd_d = fwd_q;
    rev_d = rev_q;
    cnt_d = cnt_q;
    lup_d = lup_q;
    if (advance_i) begin
      if (active) begin
        fwd_d = fwd_n;
        rev_d = rev_n;
        cnt_d = cnt_q + ckx_pkg::PosW'(1);
        lup_d = ckx_pkg::LupW'(lup_new_s);
      end
      if (step_i.req.last_in_read) begin
        fwd_d = '0;
        rev_d = '0;
        cnt_d = '0;
        lup_d = '1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
      rev_q <= '0;
      cnt_q <= '0;
      lup_q <= '1;
    end else begin
      fwd_q <= fwd_d;
      rev_q <= rev_d;
      cnt_q <= cnt_d;
      lup_q <= lup_d;
    end
  end

  // Counter never passes the read length cap
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ckx_pkg::PosW'(ckx_pkg::MaxReadLen))
    else $error("position counter beyond read length cap");

  // Recorded N always lies behind the current position
  a_lup_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lup_s < y_s)
    else $error("last N position not behind current position");

  // An end-of-read step leaves the window empty
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && step_i.req.last_in_read) |=> (cnt_q == '0 && fwd_q == '0))
    else $error("state not cleared after end of read");

endmodule

// ===== hdl/ckx_out_stage.sv =====
// ----------------------------------------------------------------------------
// ckx_out_stage
// Result register; holds a k-mer until the sink takes it.
// ----------------------------------------------------------------------------
module ckx_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ckx_pkg::kmer_res_t res_i,
  input  logic               advance_i,
  output logic               can_take_o,
  output logic               out_valid_o,
  output ckx_pkg::kmer_req_t out_req_o,
  input  logic               out_stall_i
);

  logic               valid_q, valid_d;
  ckx_pkg::kmer_req_t req_q;

  assign can_take_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_i) begin
      valid_d = res_i.valid;
    end else if (can_take_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && res_i.valid) begin
      req_q <= res_i.req;
    end
  end

  assign out_valid_o = valid_q;
  assign out_req_o   = req_q;

endmodule

// ===== hdl/canonical_kmer_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// canonical_kmer_extractor_unit
// Streams read characters and emits canonical 2-bit packed k-mers.
// ----------------------------------------------------------------------------
// Takes one read character per request and returns at most one canonical
// k-mer per character. Throughput is one character per clock while the
// output is not stalled; a taken character is held in the input register
// and its k-mer is registered in the output register. That rate is set
// by the core's state update: shift of the forward and reverse-complement
// words, the 2k mask, N tracking and the 64-bit compare are all combinational.
// kmer_length and exclude_n should only be written while the unit is idle;
// a change applies from the next character and clears no read state.
module canonical_kmer_extractor_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // character requests
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ckx_pkg::base_req_t               in_req_i,
  // k-mer results
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ckx_pkg::kmer_req_t               out_req_o,
  // register writes
  input  logic                             cfg_we_i,
  input  logic [ckx_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ckx_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  ckx_pkg::cfg_t       cfg_q, cfg_d;
  ckx_pkg::base_step_t step;
  ckx_pkg::kmer_res_t  res;
  logic                can_take;
  logic                advance;

  // --- configuration registers ---
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ckx_pkg::cfg_idx_e'(cfg_index_i))
        ckx_pkg::CfgKmerLength: cfg_d.kmer_length = cfg_wdata_i[ckx_pkg::KLenW-1:0];
        ckx_pkg::CfgExcludeN:   cfg_d.exclude_n   = cfg_wdata_i[0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kmer_length <= ckx_pkg::KReset;
      cfg_q.exclude_n   <= ckx_pkg::ExclNRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // A held character moves on whenever the result register has room,
  // including characters that produce no k-mer.
  assign advance = step.valid && can_take;

  ckx_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .in_stall_o (in_stall_o),
    .advance_i  (advance),
    .step_o     (step)
  );

  ckx_kmer_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .step_i    (step),
    .advance_i (advance),
    .res_o     (res)
  );

  ckx_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .advance_i   (advance),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o),
    .out_stall_i (out_stall_i)
  );

  // Input side only stalls while a character is held
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> step.valid)
    else $error("input stalled with empty input register");

  // A held character is not lost while the output is backed up
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.valid && out_valid_o && out_stall_i) |=> step.valid)
    else $error("character dropped under output stall");

  // Taken result with nothing new behind it empties the output
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !(advance && res.valid)) |=> !out_valid_o)
    else $error("result repeated after being taken");

endmodule

// ===== bench/canonical_kmer_extractor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// canonical_kmer_extractor_unit_tb
// Self-checking bench for the canonical k-mer extractor. Read characters
// are streamed in bursts against a stalling receiver. Every k-mer that comes
// out is compared with one worked out by a rolling forward/reverse-complement
// window kept in the bench, across several k and N-exclusion settings.
// ----------------------------------------------------------------------------
module canonical_kmer_extractor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 400;
  localparam int HoldAfter    = 700;
  localparam int PhaseItems   = 150;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // DUT-facing signals; the ones the bench drives are known from time zero
  logic                         in_valid  = 1'b0;
  ckx_pkg::base_req_t           in_req    = '0;
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic                         out_stall = 1'b0;
  ckx_pkg::kmer_req_t           out_req_o;
  logic                         cfg_we    = 1'b0;
  ckx_pkg::cfg_idx_e            cfg_index = ckx_pkg::CfgKmerLength;
  logic [ckx_pkg::CfgDataW-1:0] cfg_wdata = '0;

  // Bench copy of the registers and the read window
  logic [ckx_pkg::KLenW-1:0] cfg_k      = ckx_pkg::KReset;
  logic                      cfg_excl   = ckx_pkg::ExclNRst;
  logic [63:0]               fwd_kmer   = '0;
  logic [63:0]               rc_kmer    = '0;
  int                        win_pos    = 0;
  int                        last_n_pos = -1;

  ckx_pkg::base_req_t chars_pending[$];
  ckx_pkg::kmer_req_t kmers_due[$];
  int                 n_queued    = 0;
  int                 n_accepted  = 0;
  int                 n_mismatch  = 0;

  // Sender burst shaping
  int burst_left = 8;
  int gap_left   = 0;

  // Receiver stall pattern
  int stall_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  logic [ckx_pkg::CharW-1:0] base_set [8] = '{ckx_pkg::ChAUp, ckx_pkg::ChALo,
                                              ckx_pkg::ChCUp, ckx_pkg::ChCLo,
                                              ckx_pkg::ChGUp, ckx_pkg::ChGLo,
                                              ckx_pkg::ChTUp, ckx_pkg::ChTLo};

  canonical_kmer_extractor_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_req_o  (out_req_o),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // k as the block uses it: 0 behaves as 1, anything past 32 as 32
  function automatic int eff_k(input logic [ckx_pkg::KLenW-1:0] k_raw);
    if (k_raw == 0) return 1;
    if (k_raw > 32) return 32;
    return int'(k_raw);
  endfunction

  function automatic void classify_base(input logic [ckx_pkg::CharW-1:0] ch,
                                        output logic known,
                                        output logic [1:0] code);
    known = 1'b1;
    code  = ckx_pkg::CodeA;
    case (ch)
      ckx_pkg::ChAUp, ckx_pkg::ChALo: code = ckx_pkg::CodeA;
      ckx_pkg::ChCUp, ckx_pkg::ChCLo: code = ckx_pkg::CodeC;
      ckx_pkg::ChGUp, ckx_pkg::ChGLo: code = ckx_pkg::CodeG;
      ckx_pkg::ChTUp, ckx_pkg::ChTLo: code = ckx_pkg::CodeT;
      default:                        known = 1'b0;
    endcase
  endfunction

  // Rolls one accepted character into the window and queues the k-mer due
  task automatic advance_kmer_window(input ckx_pkg::base_req_t r);
    int                 ks;
    int                 y;
    logic [63:0]        mask;
    logic               known;
    logic [1:0]         code;
    ckx_pkg::kmer_req_t k_out;
    if (win_pos < ckx_pkg::MaxReadLen) begin
      ks   = eff_k(cfg_k);
      y    = win_pos;
      mask = (ks >= 32) ? '1 : ((64'd1 << (2 * ks)) - 64'd1);
      classify_base(r.base_char, known, code);
      // an N is not recorded when it lands (k-1)/2 - 1 after the last one
      if (cfg_excl && (r.base_char == ckx_pkg::ChNUp || r.base_char == ckx_pkg::ChNLo) &&
          y != last_n_pos + (ks - 1) / 2 - 1) begin
        last_n_pos = y;
      end
      if (known) begin
        fwd_kmer = (fwd_kmer << 2) | {62'b0, code};
        rc_kmer  = (rc_kmer >> 2) | ({62'b0, 2'd3 - code} << (2 * (ks - 1)));
      end else begin
        fwd_kmer = fwd_kmer << 2;
        rc_kmer  = rc_kmer >> 2;
      end
      fwd_kmer &= mask;
      rc_kmer  &= mask;
      if (last_n_pos <= y - ks && fwd_kmer != rc_kmer) begin
        k_out.is_reverse      = (rc_kmer < fwd_kmer);
        k_out.kmer_code       = k_out.is_reverse ? rc_kmer : fwd_kmer;
        k_out.start_position  = ckx_pkg::StartPosW'(y - ks + 1);
        k_out.kmer_read_index = r.read_index;
        kmers_due.push_back(k_out);
      end
      win_pos = y + 1;
    end
    if (r.last_in_read) begin
      fwd_kmer   = '0;
      rc_kmer    = '0;
      win_pos    = 0;
      last_n_pos = -1;
    end
  endtask

  // Driver: bursts of requests with random gaps, payload held while stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        advance_kmer_window(in_req);
        n_accepted++;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (chars_pending.size() != 0) begin
          in_valid <= 1'b1;
          in_req   <= chars_pending.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken k-mer, then picks the next stall value
  always @(posedge clk_i) begin
    ckx_pkg::kmer_req_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (kmers_due.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: unexpected k-mer %h rev %0b pos %0d read %0d", $realtime,
                     out_req_o.kmer_code, out_req_o.is_reverse,
                     out_req_o.start_position, out_req_o.kmer_read_index);
        end else begin
          want = kmers_due.pop_front();
          if (out_req_o.kmer_code !== want.kmer_code ||
              out_req_o.is_reverse !== want.is_reverse ||
              out_req_o.start_position !== want.start_position ||
              out_req_o.kmer_read_index !== want.kmer_read_index) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("%0t: k-mer mismatch exp %h/%0b/%0d/%0d got %h/%0b/%0d/%0d",
                       $realtime, want.kmer_code, want.is_reverse,
                       want.start_position, want.kmer_read_index,
                       out_req_o.kmer_code, out_req_o.is_reverse,
                       out_req_o.start_position, out_req_o.kmer_read_index);
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 4);
        mode_left  = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      // one long hold-off so the block backs up and stalls its input
      if (!hold_done && n_accepted >= HoldAfter) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 6);
          3:       out_stall <= ~out_stall;
          default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
        endcase
      end
    end
  end

  task automatic queue_char(input logic [ckx_pkg::CharW-1:0] ch,
                            input logic [ckx_pkg::ReadIdxW-1:0] ridx,
                            input logic last);
    ckx_pkg::base_req_t r;
    r.base_char    = ch;
    r.read_index   = ridx;
    r.last_in_read = last;
    chars_pending.push_back(r);
    n_queued++;
  endtask

  task automatic queue_text(input string s, input logic [ckx_pkg::ReadIdxW-1:0] ridx,
                            input bit close);
    for (int i = 0; i < s.len(); i++)
      queue_char(s[i], ridx, close && (i == s.len() - 1));
  endtask

  task automatic queue_read(input int len, input int n_pct, input int junk_pct,
                            input bit close);
    logic [ckx_pkg::ReadIdxW-1:0] ridx;
    logic [ckx_pkg::CharW-1:0]    ch;
    int                           roll;
    if ($urandom_range(0, 7) == 0)
      ridx = $urandom_range(0, 1) ? '1 : '0;
    else
      ridx = ckx_pkg::ReadIdxW'($urandom_range(0, 24'hFFFFFF));
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < n_pct)
        ch = $urandom_range(0, 1) ? ckx_pkg::ChNUp : ckx_pkg::ChNLo;
      else if (roll < n_pct + junk_pct)
        ch = ckx_pkg::CharW'($urandom_range(0, 255));
      else
        ch = base_set[$urandom_range(0, 7)];
      queue_char(ch, ridx, close && (i == len - 1));
    end
  endtask

  // Sender holds off until every queued request is taken and answered
  task automatic wait_drained();
    while (n_accepted != n_queued || kmers_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [ckx_pkg::KLenW-1:0] k_raw, input logic excl);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= ckx_pkg::CfgKmerLength;
    cfg_wdata <= k_raw;
    @(posedge clk_i);
    cfg_index <= ckx_pkg::CfgExcludeN;
    cfg_wdata <= {5'($urandom_range(0, 31)), excl};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cfg_k    = k_raw;
    cfg_excl = excl;
  endtask

  initial begin
    static int phase_k    [9] = '{32, 1, 21, 7, 63, 3, 0, 16, 5};
    static bit phase_excl [9] = '{1, 0, 1, 1, 0, 1, 1, 0, 1};
    static int phase_n    [9] = '{3, 6, 4, 8, 2, 10, 5, 3, 20};
    int items;
    int keff;
    int len;
    while (!rst_ni) @(posedge clk_i);

    // k = 5: an N at position 0 sits on the skipped offset, so the first
    // k-mer still comes at k-1; the later N is recorded and blocks the tail
    program_regs(6'd5, 1'b1);
    queue_text("NACGTNa", 24'h000000, 1'b1);
    wait_drained();

    // k = 2, N kept: palindrome AT emits nothing, unknown chars shift in A
    program_regs(6'd2, 1'b0);
    queue_text("AT", 24'hFFFFFF, 1'b1);
    queue_char(ckx_pkg::ChNUp, 24'h5A5A5A, 1'b0);
    queue_char(8'hFF, 24'h5A5A5A, 1'b0);
    queue_char(8'h00, 24'h5A5A5A, 1'b0);
    queue_text("gc", 24'h5A5A5A, 1'b1);
    wait_drained();

    // k register at zero behaves as single-base k-mers
    program_regs(6'd0, 1'b1);
    queue_text("tC", 24'hA5A5A5, 1'b1);
    wait_drained();

    // Random phases; a phase may end mid-read so a write lands mid-read
    for (int p = 0; p < 9; p++) begin
      program_regs(phase_k[p][ckx_pkg::KLenW-1:0], phase_excl[p]);
      keff  = eff_k(phase_k[p][ckx_pkg::KLenW-1:0]);
      items = 0;
      while (items < PhaseItems) begin
        if ($urandom_range(0, 9) == 0)
          len = $urandom_range(1, 3 * keff + 20);
        else
          len = $urandom_range(1, keff + 12);
        queue_read(len, phase_n[p], 3, (items + len < PhaseItems) || ($urandom_range(0, 2) != 0));
        items += len;
      end
      wait_drained();
    end

    // Closing read at k = 12; the last phase may have left its read open
    program_regs(6'd12, 1'b1);
    queue_read(20, 0, 0, 1'b1);
    wait_drained();

    n_mismatch += kmers_due.size();
    if (n_mismatch == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #6000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
